### rtl/dtlb_pkg.sv
// Shared constants, codes and lookup functions of the dual traffic lamp blinker.
package dtlb_pkg;

  // Number of lamps: inner green, yellow, red, then outer green, yellow, red.
  localparam int unsigned NUM_LAMPS = 6;
  localparam int unsigned LAMPS_PER_SIGNAL = 3;
  localparam int unsigned LAMP_IDX_W = 3;

  // Default width of the period and elapsed-tick counters.
  localparam int unsigned TIME_BITS = 16;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // A toggle count of all ones means the lamp blinks forever.
  localparam logic [COUNT_W-1:0] TOGGLE_FOREVER = 8'hff;

  // Reset value of the blink period register.
  localparam logic [CFG_DATA_W-1:0] BLINK_PERIOD_RESET = 16'd500;

  // Request operation codes.
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_NAMED = 2'd1;
  localparam logic [1:0] OP_PATTERN = 2'd2;
  localparam logic [1:0] OP_SET_LAMP = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = 1'b1;

  // Named states.
  localparam logic [2:0] STATE_OFF = 3'd0;
  localparam logic [2:0] STATE_NEEDCODE = 3'd1;
  localparam logic [2:0] STATE_CONFLICT = 3'd2;
  localparam logic [2:0] STATE_ACCEPTED = 3'd3;
  localparam logic [2:0] STATE_DENIED = 3'd4;
  localparam logic [2:0] STATE_PASS = 3'd5;

  // Bit positions of the nibbles inside a pattern word.
  localparam int unsigned SLAVE_ON_LSB = 0;
  localparam int unsigned SLAVE_BLINK_LSB = 4;
  localparam int unsigned MASTER_ON_LSB = 8;
  localparam int unsigned MASTER_BLINK_LSB = 12;

  // True when the index names one of the six states.
  function automatic logic named_valid(input logic [2:0] idx);
    logic ok;
    ok = 1'b0;
    case (idx)
      STATE_OFF, STATE_NEEDCODE, STATE_CONFLICT,
      STATE_ACCEPTED, STATE_DENIED, STATE_PASS: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Pattern word of a named state.
  function automatic logic [WORD_W-1:0] named_word(input logic [2:0] idx);
    logic [WORD_W-1:0] w;
    w = 16'h0000;
    case (idx)
      STATE_OFF: w = 16'h0000;
      STATE_NEEDCODE: w = 16'h0204;
      STATE_CONFLICT: w = 16'h2244;
      STATE_ACCEPTED: w = 16'h0104;
      STATE_DENIED: w = 16'h4404;
      STATE_PASS: w = 16'h0404;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

### rtl/dual_traffic_lamp_blinker_unit.sv
// Top level of the dual traffic lamp blinker: lamp timers, pattern decode and result register.
//
// This block drives the six lamps of an inner and an outer signal (green, yellow and red
// for each) and takes one request per clock cycle whenever its result register is free or
// being emptied in the same cycle. A request is either a tick, which advances every blinking
// lamp by one step, a named state or a raw pattern word, which reloads all six lamps at once,
// or a write of a single lamp. The whole update is done in one pass of combinational logic
// from the lamp state registers to their next values, so every request reaches the result
// register in the cycle after it is taken and the next request can follow at once; the result
// register is the only place where the two sides can hold each other up. Each result shows
// the lamp states after its request has been applied, both as logical on bits and as pin
// levels after the polarity setting. The blink period and polarity registers must only be
// written while no request is outstanding; the pin levels of a result are fixed at the
// moment its request is taken.
module dual_traffic_lamp_blinker_unit #(
  parameter int unsigned TimeBits = dtlb_pkg::TIME_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [dtlb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dtlb_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Request channel.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           op_i,
  input  logic [2:0]                           state_index_i,
  input  logic [dtlb_pkg::WORD_W-1:0]          pattern_i,
  input  logic                                 inner_master_i,
  input  logic [dtlb_pkg::LAMP_IDX_W-1:0]      lamp_index_i,
  input  logic                                 lamp_on_i,
  input  logic [15:0]                          lamp_period_i,
  input  logic [dtlb_pkg::COUNT_W-1:0]         toggle_count_i,
  input  logic                                 end_off_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [dtlb_pkg::NUM_LAMPS-1:0]       lamp_levels_o,
  output logic [dtlb_pkg::NUM_LAMPS-1:0]       lamps_lit_o
);

  localparam int unsigned NumLamps = dtlb_pkg::NUM_LAMPS;
  localparam int unsigned PerSignal = dtlb_pkg::LAMPS_PER_SIGNAL;

  // Configuration registers.
  logic [dtlb_pkg::CFG_DATA_W-1:0] blink_period_q;
  logic                            active_high_q;

  // Per-lamp state.
  logic [NumLamps-1:0]              lit_q, lit_d;
  logic [TimeBits-1:0]              period_q [NumLamps];
  logic [TimeBits-1:0]              period_d [NumLamps];
  logic [dtlb_pkg::COUNT_W-1:0]     toggles_q [NumLamps];
  logic [dtlb_pkg::COUNT_W-1:0]     toggles_d [NumLamps];
  logic [NumLamps-1:0]              off_end_q, off_end_d;
  logic [TimeBits-1:0]              elapsed_q [NumLamps];
  logic [TimeBits-1:0]              elapsed_d [NumLamps];

  // Result register.
  logic                  out_valid_q;
  logic [NumLamps-1:0]   levels_q;
  logic [NumLamps-1:0]   lit_out_q;

  logic in_accept;
  logic [dtlb_pkg::WORD_W-1:0] word;
  logic word_load;
  logic [TimeBits-1:0] blink_time;
  logic [TimeBits-1:0] single_time;

  // A request is taken whenever the result register is empty or is being read this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Periods are stored at the timer width, cut or zero-extended as it requires.
  assign blink_time  = TimeBits'(blink_period_q);
  assign single_time = TimeBits'(lamp_period_i);

  // A named state is simply a fixed pattern word; an unknown state loads nothing.
  always_comb begin
    word      = pattern_i;
    word_load = 1'b0;
    case (op_i)
      dtlb_pkg::OP_NAMED: begin
        word      = dtlb_pkg::named_word(state_index_i);
        word_load = dtlb_pkg::named_valid(state_index_i);
      end
      dtlb_pkg::OP_PATTERN: begin
        word      = pattern_i;
        word_load = 1'b1;
      end
      default: begin
        word      = pattern_i;
        word_load = 1'b0;
      end
    endcase
  end

  // Next state of every lamp. The six lamps are independent, so each gets its own copy of
  // the timer and load logic.
  always_comb begin
    logic [TimeBits-1:0] next_elapsed;
    logic                is_master;
    logic                pat_on;
    logic                pat_blink;
    int unsigned         colour;
    for (int k = 0; k < NumLamps; k++) begin
      lit_d[k]     = lit_q[k];
      period_d[k]  = period_q[k];
      toggles_d[k] = toggles_q[k];
      off_end_d[k] = off_end_q[k];
      elapsed_d[k] = elapsed_q[k];

      next_elapsed = elapsed_q[k] + TimeBits'(1);
      // Inner lamps take the master nibbles when inner_master is set, outer lamps otherwise.
      is_master = ((k < PerSignal) == inner_master_i);
      colour    = k % PerSignal;
      pat_on    = is_master ? word[dtlb_pkg::MASTER_ON_LSB + colour]
                            : word[dtlb_pkg::SLAVE_ON_LSB + colour];
      pat_blink = is_master ? word[dtlb_pkg::MASTER_BLINK_LSB + colour]
                            : word[dtlb_pkg::SLAVE_BLINK_LSB + colour];

      case (op_i)
        dtlb_pkg::OP_TICK: begin
          // Steady lamps do not count; a blinking lamp acts when its period has expired.
          if (period_q[k] != '0) begin
            if (next_elapsed < period_q[k]) begin
              elapsed_d[k] = next_elapsed;
            end else begin
              if (toggles_q[k] != '0) begin
                lit_d[k] = !lit_q[k];
                if (toggles_q[k] != dtlb_pkg::TOGGLE_FOREVER) begin
                  toggles_d[k] = toggles_q[k] - 8'd1;
                end
              end else begin
                if (off_end_q[k]) begin
                  lit_d[k] = 1'b0;
                end
                period_d[k] = '0;
              end
              elapsed_d[k] = '0;
            end
          end
        end
        dtlb_pkg::OP_NAMED, dtlb_pkg::OP_PATTERN: begin
          if (word_load) begin
            lit_d[k]     = pat_on;
            period_d[k]  = pat_blink ? blink_time : '0;
            toggles_d[k] = dtlb_pkg::TOGGLE_FOREVER;
            off_end_d[k] = 1'b1;
            elapsed_d[k] = '0;
          end
        end
        dtlb_pkg::OP_SET_LAMP: begin
          // An index beyond the last lamp matches no lamp and so changes nothing.
          if (lamp_index_i == dtlb_pkg::LAMP_IDX_W'(k)) begin
            lit_d[k]     = lamp_on_i;
            period_d[k]  = single_time;
            toggles_d[k] = toggle_count_i;
            off_end_d[k] = end_off_i;
            elapsed_d[k] = '0;
          end
        end
        default: begin
          lit_d[k] = lit_q[k];
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_period_q <= dtlb_pkg::BLINK_PERIOD_RESET;
      active_high_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dtlb_pkg::REG_BLINK_PERIOD: blink_period_q <= cfg_data_i;
        dtlb_pkg::REG_ACTIVE_HIGH: active_high_q <= cfg_data_i[0];
        default: active_high_q <= active_high_q;
      endcase
    end
  end

  // Lamp state, updated once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q     <= '0;
      off_end_q <= '0;
      for (int k = 0; k < NumLamps; k++) begin
        period_q[k]  <= '0;
        toggles_q[k] <= '0;
        elapsed_q[k] <= '0;
      end
    end else if (in_accept) begin
      lit_q     <= lit_d;
      off_end_q <= off_end_d;
      for (int k = 0; k < NumLamps; k++) begin
        period_q[k]  <= period_d[k];
        toggles_q[k] <= toggles_d[k];
        elapsed_q[k] <= elapsed_d[k];
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: the lamp states after the request, raw and with polarity applied.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      lit_out_q <= lit_d;
      levels_q  <= active_high_q ? lit_d : ~lit_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign lamp_levels_o = levels_q;
  assign lamps_lit_o   = lit_out_q;

endmodule

### verif/dual_traffic_lamp_blinker_unit_tb.sv
// Self-checking testbench of the dual traffic lamp blinker: directed and random requests.
`timescale 1ns / 100ps

module dual_traffic_lamp_blinker_unit_tb;

  // Pattern words of the named states.
  localparam logic [dtlb_pkg::WORD_W-1:0] WORD_OFF = 16'h0000;
  localparam logic [dtlb_pkg::WORD_W-1:0] WORD_NEEDCODE = 16'h0204;
  localparam logic [dtlb_pkg::WORD_W-1:0] WORD_CONFLICT = 16'h2244;
  localparam logic [dtlb_pkg::WORD_W-1:0] WORD_ACCEPTED = 16'h0104;
  localparam logic [dtlb_pkg::WORD_W-1:0] WORD_DENIED = 16'h4404;
  localparam logic [dtlb_pkg::WORD_W-1:0] WORD_PASS = 16'h0404;

  // State and lamp indexes; the spare ones lie beyond the defined ones and the block must ignore them.
  localparam logic [2:0] STATE_SPARE_LO = 3'd6;
  localparam logic [2:0] STATE_SPARE_HI = 3'd7;
  localparam logic [dtlb_pkg::LAMP_IDX_W-1:0] LAMP_IN_GREEN = 3'd0;
  localparam logic [dtlb_pkg::LAMP_IDX_W-1:0] LAMP_IN_RED = 3'd2;
  localparam logic [dtlb_pkg::LAMP_IDX_W-1:0] LAMP_OUT_GREEN = 3'd3;
  localparam logic [dtlb_pkg::LAMP_IDX_W-1:0] LAMP_OUT_YELLOW = 3'd4;
  localparam logic [dtlb_pkg::LAMP_IDX_W-1:0] LAMP_OUT_RED = 3'd5;
  localparam logic [dtlb_pkg::LAMP_IDX_W-1:0] LAMP_SPARE_LO = 3'd6;
  localparam logic [dtlb_pkg::LAMP_IDX_W-1:0] LAMP_SPARE_HI = 3'd7;

  localparam int unsigned IDLE_PERCENT = 29;

  typedef struct packed {
    logic [1:0]                      op;
    logic [2:0]                      state_index;
    logic [dtlb_pkg::WORD_W-1:0]     pattern;
    logic                            inner_master;
    logic [dtlb_pkg::LAMP_IDX_W-1:0] lamp_index;
    logic                            lamp_on;
    logic [15:0]                     lamp_period;
    logic [dtlb_pkg::COUNT_W-1:0]    toggle_count;
    logic                            end_off;
  } lamp_request_t;

  typedef struct packed {
    logic [dtlb_pkg::NUM_LAMPS-1:0] levels;
    logic [dtlb_pkg::NUM_LAMPS-1:0] lit;
  } lamp_result_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [dtlb_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [dtlb_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [1:0]                      op_i;
  logic [2:0]                      state_index_i;
  logic [dtlb_pkg::WORD_W-1:0]     pattern_i;
  logic                            inner_master_i;
  logic [dtlb_pkg::LAMP_IDX_W-1:0] lamp_index_i;
  logic                            lamp_on_i;
  logic [15:0]                     lamp_period_i;
  logic [dtlb_pkg::COUNT_W-1:0]    toggle_count_i;
  logic                            end_off_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [dtlb_pkg::NUM_LAMPS-1:0]  lamp_levels_o;
  logic [dtlb_pkg::NUM_LAMPS-1:0]  lamps_lit_o;

  dual_traffic_lamp_blinker_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .state_index_i  (state_index_i),
    .pattern_i      (pattern_i),
    .inner_master_i (inner_master_i),
    .lamp_index_i   (lamp_index_i),
    .lamp_on_i      (lamp_on_i),
    .lamp_period_i  (lamp_period_i),
    .toggle_count_i (toggle_count_i),
    .end_off_i      (end_off_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .lamp_levels_o  (lamp_levels_o),
    .lamps_lit_o    (lamps_lit_o)
  );

  // Lamp state as the block should hold it, plus the two registers.
  logic [dtlb_pkg::NUM_LAMPS-1:0]  lit_q;
  logic [dtlb_pkg::TIME_BITS-1:0]  period_q [dtlb_pkg::NUM_LAMPS];
  logic [dtlb_pkg::COUNT_W-1:0]    toggles_q [dtlb_pkg::NUM_LAMPS];
  logic [dtlb_pkg::NUM_LAMPS-1:0]  end_off_q;
  logic [dtlb_pkg::TIME_BITS-1:0]  elapsed_q [dtlb_pkg::NUM_LAMPS];
  logic [dtlb_pkg::CFG_DATA_W-1:0] blink_period_q;
  logic                            active_high_q;

  lamp_result_t expected_lamps [$];
  int unsigned  requests_sent;
  int unsigned  results_checked;
  int unsigned  error_count;
  bit           steady_flow;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void load_lamp(int unsigned k, logic on,
                                    logic [dtlb_pkg::TIME_BITS-1:0] per,
                                    logic [dtlb_pkg::COUNT_W-1:0] cnt, logic eo);
    lit_q[k] = on;
    period_q[k] = per;
    toggles_q[k] = cnt;
    end_off_q[k] = eo;
    elapsed_q[k] = '0;
  endfunction

  // One tick: every blinking lamp counts up, and toggles or ends once its period is up.
  function automatic void advance_lamps();
    for (int k = 0; k < dtlb_pkg::NUM_LAMPS; k++) begin
      if (period_q[k] != '0) begin
        elapsed_q[k] = elapsed_q[k] + {{(dtlb_pkg::TIME_BITS-1){1'b0}}, 1'b1};
        if (elapsed_q[k] >= period_q[k]) begin
          if (toggles_q[k] != '0) begin
            lit_q[k] = ~lit_q[k];
            if (toggles_q[k] != dtlb_pkg::TOGGLE_FOREVER) toggles_q[k] = toggles_q[k] - 8'd1;
          end else begin
            if (end_off_q[k]) lit_q[k] = 1'b0;
            period_q[k] = '0;
          end
          elapsed_q[k] = '0;
        end
      end
    end
  endfunction

  function automatic void apply_word(logic [dtlb_pkg::WORD_W-1:0] w, logic inner);
    int unsigned mbase;
    int unsigned sbase;
    mbase = inner ? 0 : dtlb_pkg::LAMPS_PER_SIGNAL;
    sbase = inner ? dtlb_pkg::LAMPS_PER_SIGNAL : 0;
    for (int c = 0; c < dtlb_pkg::LAMPS_PER_SIGNAL; c++) begin
      load_lamp(mbase + c, w[dtlb_pkg::MASTER_ON_LSB + c],
                w[dtlb_pkg::MASTER_BLINK_LSB + c] ? blink_period_q : '0,
                dtlb_pkg::TOGGLE_FOREVER, 1'b1);
      load_lamp(sbase + c, w[dtlb_pkg::SLAVE_ON_LSB + c],
                w[dtlb_pkg::SLAVE_BLINK_LSB + c] ? blink_period_q : '0,
                dtlb_pkg::TOGGLE_FOREVER, 1'b1);
    end
  endfunction

  function automatic logic [dtlb_pkg::WORD_W-1:0] state_word(logic [2:0] idx);
    logic [dtlb_pkg::WORD_W-1:0] w;
    case (idx)
      dtlb_pkg::STATE_NEEDCODE: w = WORD_NEEDCODE;
      dtlb_pkg::STATE_CONFLICT: w = WORD_CONFLICT;
      dtlb_pkg::STATE_ACCEPTED: w = WORD_ACCEPTED;
      dtlb_pkg::STATE_DENIED: w = WORD_DENIED;
      dtlb_pkg::STATE_PASS: w = WORD_PASS;
      default: w = WORD_OFF;
    endcase
    return w;
  endfunction

  // Applies one request to the lamp state and returns the lamps that should be shown.
  function automatic lamp_result_t next_lamps(lamp_request_t r);
    lamp_result_t res;
    case (r.op)
      dtlb_pkg::OP_TICK: advance_lamps();
      dtlb_pkg::OP_NAMED: begin
        if (r.state_index <= dtlb_pkg::STATE_PASS) begin
          apply_word(state_word(r.state_index), r.inner_master);
        end
      end
      dtlb_pkg::OP_PATTERN: apply_word(r.pattern, r.inner_master);
      dtlb_pkg::OP_SET_LAMP: begin
        if (r.lamp_index < dtlb_pkg::NUM_LAMPS) begin
          load_lamp(int'(r.lamp_index), r.lamp_on, r.lamp_period, r.toggle_count, r.end_off);
        end
      end
      default: ;
    endcase
    res.lit = lit_q;
    res.levels = active_high_q ? lit_q : ~lit_q;
    return res;
  endfunction

  // Random request: mostly short periods and few toggles, so lamps really blink and run out.
  function automatic lamp_request_t random_request();
    lamp_request_t r;
    int unsigned sel;
    logic [31:0] raw;
    sel = $urandom_range(99);
    if (sel < 52) r.op = dtlb_pkg::OP_TICK;
    else if (sel < 64) r.op = dtlb_pkg::OP_NAMED;
    else if (sel < 77) r.op = dtlb_pkg::OP_PATTERN;
    else r.op = dtlb_pkg::OP_SET_LAMP;
    r.state_index = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6))
                                              : 3'($urandom_range(5));
    raw = $urandom;
    r.pattern = raw[dtlb_pkg::WORD_W-1:0];
    r.inner_master = 1'($urandom_range(1));
    r.lamp_index = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6))
                                             : 3'($urandom_range(5));
    r.lamp_on = 1'($urandom_range(1));
    sel = $urandom_range(99);
    raw = $urandom;
    if (sel < 60) r.lamp_period = 16'($urandom_range(4, 1));
    else if (sel < 72) r.lamp_period = '0;
    else if (sel < 80) r.lamp_period = 16'hffff;
    else if (sel < 90) r.lamp_period = 16'($urandom_range(12, 5));
    else r.lamp_period = raw[15:0];
    sel = $urandom_range(99);
    raw = $urandom;
    if (sel < 50) r.toggle_count = 8'($urandom_range(4));
    else if (sel < 75) r.toggle_count = dtlb_pkg::TOGGLE_FOREVER;
    else r.toggle_count = raw[dtlb_pkg::COUNT_W-1:0];
    r.end_off = 1'($urandom_range(1));
    return r;
  endfunction

  // The result side stalls at random unless a steady stretch is running.
  always @(posedge clk_i) begin
    out_stall_i <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Every accepted result is compared with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    lamp_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_lamps.size() == 0) begin
        $error("result with no request outstanding: levels %h lit %h",
               lamp_levels_o, lamps_lit_o);
        error_count++;
      end else begin
        exp_res = expected_lamps.pop_front();
        results_checked++;
        if (lamp_levels_o !== exp_res.levels) begin
          $error("lamp_levels: expected %h, got %h", exp_res.levels, lamp_levels_o);
          error_count++;
        end
        if (lamps_lit_o !== exp_res.lit) begin
          $error("lamps_lit: expected %h, got %h", exp_res.lit, lamps_lit_o);
          error_count++;
        end
      end
    end
  end

  // Offers one request, with a random gap first, and records its expectation on acceptance.
  // Valid stays high afterwards; the next call or a drain decides what it does next.
  task automatic send_request(lamp_request_t r);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= r.op;
    state_index_i <= r.state_index;
    pattern_i <= r.pattern;
    inner_master_i <= r.inner_master;
    lamp_index_i <= r.lamp_index;
    lamp_on_i <= r.lamp_on;
    lamp_period_i <= r.lamp_period;
    toggle_count_i <= r.toggle_count;
    end_off_i <= r.end_off;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_lamps.push_back(next_lamps(r));
    requests_sent++;
  endtask

  task automatic send_tick(int unsigned n);
    lamp_request_t r;
    repeat (n) begin
      r = random_request();
      r.op = dtlb_pkg::OP_TICK;
      send_request(r);
    end
  endtask

  task automatic send_named(logic [2:0] idx, logic inner);
    lamp_request_t r;
    r = random_request();
    r.op = dtlb_pkg::OP_NAMED;
    r.state_index = idx;
    r.inner_master = inner;
    send_request(r);
  endtask

  task automatic send_pattern(logic [dtlb_pkg::WORD_W-1:0] w, logic inner);
    lamp_request_t r;
    r = random_request();
    r.op = dtlb_pkg::OP_PATTERN;
    r.pattern = w;
    r.inner_master = inner;
    send_request(r);
  endtask

  task automatic send_lamp(logic [dtlb_pkg::LAMP_IDX_W-1:0] idx, logic on, logic [15:0] per,
                           logic [dtlb_pkg::COUNT_W-1:0] cnt, logic eo);
    lamp_request_t r;
    r = random_request();
    r.op = dtlb_pkg::OP_SET_LAMP;
    r.lamp_index = idx;
    r.lamp_on = on;
    r.lamp_period = per;
    r.toggle_count = cnt;
    r.end_off = eo;
    send_request(r);
  endtask

  // Holds back new requests until every outstanding result has been taken.
  task automatic wait_results_settled();
    in_valid_i <= 1'b0;
    while (expected_lamps.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [dtlb_pkg::CFG_IDX_W-1:0] idx,
                           logic [dtlb_pkg::CFG_DATA_W-1:0] data);
    wait_results_settled();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == dtlb_pkg::REG_BLINK_PERIOD) blink_period_q = data;
    else active_high_q = data[0];
  endtask

  // Every named state, each on one of the two masters, the word extremes, lamps out of range,
  // a lamp with no toggles that must end after one period, and some ticks.
  task automatic test_directed();
    write_reg(dtlb_pkg::REG_BLINK_PERIOD, 16'd2);
    send_tick(1);
    send_named(dtlb_pkg::STATE_OFF, 1'b1);
    send_named(dtlb_pkg::STATE_NEEDCODE, 1'b1);
    send_named(dtlb_pkg::STATE_CONFLICT, 1'b0);
    send_named(dtlb_pkg::STATE_ACCEPTED, 1'b1);
    send_named(dtlb_pkg::STATE_DENIED, 1'b0);
    send_named(dtlb_pkg::STATE_PASS, 1'b1);
    send_named(STATE_SPARE_LO, 1'b0);
    send_named(STATE_SPARE_HI, 1'b1);
    send_pattern(16'hffff, 1'b0);
    send_tick(2);
    send_pattern(16'h0000, 1'b1);
    send_lamp(LAMP_IN_GREEN, 1'b1, 16'hffff, dtlb_pkg::TOGGLE_FOREVER, 1'b0);
    send_lamp(LAMP_OUT_RED, 1'b1, 16'd2, 8'd0, 1'b1);
    send_lamp(LAMP_OUT_YELLOW, 1'b1, 16'd1, 8'd2, 1'b0);
    send_lamp(LAMP_IN_RED, 1'b1, 16'd0, 8'd3, 1'b1);
    send_lamp(LAMP_SPARE_LO, 1'b1, 16'd1, 8'd1, 1'b1);
    send_lamp(LAMP_SPARE_HI, 1'b1, 16'd1, 8'd1, 1'b1);
    send_tick(4);
    send_lamp(LAMP_OUT_GREEN, 1'b0, 16'd1, 8'd1, 1'b0);
    send_tick(2);
  endtask

  task automatic test_random_phase(int unsigned n, logic [dtlb_pkg::CFG_DATA_W-1:0] period,
                                   logic polarity);
    write_reg(dtlb_pkg::REG_BLINK_PERIOD, period);
    write_reg(dtlb_pkg::REG_ACTIVE_HIGH, {{(dtlb_pkg::CFG_DATA_W-1){1'b0}}, polarity});
    repeat (n) send_request(random_request());
  endtask

  // A stretch with neither side idling, so requests follow back to back.
  task automatic test_back_to_back(int unsigned n);
    steady_flow = 1'b1;
    test_random_phase(n, 16'($urandom_range(6, 2)), 1'b1);
    wait_results_settled();
    steady_flow = 1'b0;
  endtask

  initial begin
    int unsigned waited;
    lamp_result_t init_res;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= dtlb_pkg::REG_BLINK_PERIOD;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    op_i <= dtlb_pkg::OP_TICK;
    state_index_i <= dtlb_pkg::STATE_OFF;
    pattern_i <= '0;
    inner_master_i <= 1'b0;
    lamp_index_i <= LAMP_IN_GREEN;
    lamp_on_i <= 1'b0;
    lamp_period_i <= '0;
    toggle_count_i <= '0;
    end_off_i <= 1'b0;
    out_stall_i <= 1'b0;
    steady_flow = 1'b0;
    requests_sent = 0;
    results_checked = 0;
    error_count = 0;
    blink_period_q = dtlb_pkg::BLINK_PERIOD_RESET;
    active_high_q = 1'b1;
    for (int k = 0; k < dtlb_pkg::NUM_LAMPS; k++) load_lamp(k, 1'b0, '0, '0, 1'b0);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phase(315, 16'd1, 1'b1);
    test_random_phase(315, 16'd3, 1'b0);
    test_random_phase(315, 16'd0, 1'b1);
    test_random_phase(315, 16'hffff, 1'b0);
    test_back_to_back(315);

    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_lamps.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    while (expected_lamps.size() != 0) begin
      init_res = expected_lamps.pop_front();
      $error("request never answered: expected levels %h lit %h", init_res.levels, init_res.lit);
      error_count++;
    end

    $display("Run covered %0d requests: named states, raw words, single lamps and ticks,",
             requests_sent);
    $display("blink periods from 0 to 65535, both polarities; %0d results compared.",
             results_checked);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
